// ===== design/bnsu_pkg.sv =====
// Shared types and constants for the boolean network synchronous update block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bnsu_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int MAX_GENES_DEF  = 32;
    localparam int MAX_INPUTS_DEF = 4;

    // Fixed field widths of the item and register interface.
    localparam int ACTION_W   = 2;
    localparam int GENE_W     = 5;
    localparam int SLOT_W     = 2;
    localparam int SRC_W      = 6;
    localparam int COL_W      = 16;
    localparam int VEC_W      = 32;
    localparam int AGENES_W   = 6;
    localparam int AINPUTS_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Lookup index bits that address one truth column.
    localparam int COL_IDX_W = 4;

    // Register reset values.
    localparam logic [AGENES_W-1:0]  AGENES_RST  = 6'd32;
    localparam logic [AINPUTS_W-1:0] AINPUTS_RST = 3'd4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WIRE   = 2'd0,
        ACT_COLUMN = 2'd1,
        ACT_STATE  = 2'd2,
        ACT_STEP   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_GENES  = 1'b0,
        CFG_ACTIVE_INPUTS = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } fsm_t;

    // Table write request from the sequencer.
    typedef struct packed {
        logic              wire_we;
        logic              col_we;
        logic [GENE_W-1:0] gene;
        logic [SLOT_W-1:0] slot;
        logic [SRC_W-1:0]  src;
        logic [COL_W-1:0]  column;
    } tbl_wr_t;

    // Per-gene evaluation result.
    typedef struct packed {
        logic used;
        logic nbit;
    } eval_res_t;

endpackage

`default_nettype wire

// ===== design/bnsu_tables.sv =====
// Wiring and truth column storage: one memory per wiring slot plus the column memory.
// Row valid flops make unwritten wiring rows read as unused. Depends on bnsu_pkg.
`default_nettype none

module bnsu_tables #(
    parameter int MAX_GENES  = bnsu_pkg::MAX_GENES_DEF,
    parameter int MAX_INPUTS = bnsu_pkg::MAX_INPUTS_DEF,
    localparam int GIdxW     = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire bnsu_pkg::tbl_wr_t                             wr,
    input  wire logic [GIdxW-1:0]                              rd_addr,
    output logic      [MAX_INPUTS-1:0][bnsu_pkg::SRC_W-1:0]    src,
    output logic      [bnsu_pkg::COL_W-1:0]                    column
);
    import bnsu_pkg::*;

    logic [MAX_GENES-1:0] row_valid_reg;
    logic                 rv_q_reg;
    logic [GIdxW-1:0]     wr_addr;
    logic                 wire_ok;
    logic                 col_ok;
    logic [COL_W-1:0]     col_mem [MAX_GENES];
    logic [COL_W-1:0]     col_q_reg;

    assign wr_addr = GIdxW'(wr.gene);
    assign col_ok  = wr.col_we && (int'(wr.gene) < MAX_GENES);
    assign wire_ok = wr.wire_we && (int'(wr.gene) < MAX_GENES)
                     && (int'(wr.slot) < MAX_INPUTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wire_ok)
        begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_q_reg <= row_valid_reg[rd_addr];
    end

    // First write into a row zeroes the other slots of that row.
    for (genvar s = 0; s < MAX_INPUTS; s++)
    begin : g_slot
        logic [SRC_W-1:0] wire_mem [MAX_GENES];
        logic [SRC_W-1:0] q_reg;
        logic             hit;

        assign hit = (int'(wr.slot) == s);

        always_ff @(posedge clk)
        begin
            if (wire_ok && (hit || !row_valid_reg[wr_addr]))
            begin
                wire_mem[wr_addr] <= hit ? wr.src : '0;
            end
            q_reg <= wire_mem[rd_addr];
        end

        assign src[s] = rv_q_reg ? q_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (col_ok)
        begin
            col_mem[wr_addr] <= wr.column;
        end
        col_q_reg <= col_mem[rd_addr];
    end

    assign column = col_q_reg;

endmodule

`default_nettype wire

// ===== design/bnsu_eval.sv =====
// Gene evaluator: builds the lookup index from the used sources and picks the column bit.
// Shared by every gene of a step. Depends on bnsu_pkg.
`default_nettype none

module bnsu_eval #(
    parameter int MAX_GENES  = bnsu_pkg::MAX_GENES_DEF,
    parameter int MAX_INPUTS = bnsu_pkg::MAX_INPUTS_DEF
) (
    input  wire logic [MAX_INPUTS-1:0][bnsu_pkg::SRC_W-1:0] src,
    input  wire logic [bnsu_pkg::COL_W-1:0]                 column,
    input  wire logic [MAX_GENES-1:0]                       state_vec,
    input  wire logic [bnsu_pkg::AINPUTS_W-1:0]             active_inputs,
    output bnsu_pkg::eval_res_t                             res
);
    import bnsu_pkg::*;

    always_comb
    begin
        logic [COL_IDX_W-1:0] idx;
        logic                 ovf;
        logic                 used;
        logic [MAX_GENES-1:0] shifted;

        idx  = '0;
        ovf  = 1'b0;
        used = 1'b0;
        for (int s = 0; s < MAX_INPUTS; s++)
        begin
            // sources past the last gene shift out to zero
            shifted = state_vec >> (src[s] - SRC_W'(1));
            if ((int'(active_inputs) > s) && (src[s] != '0))
            begin
                used = 1'b1;
                ovf  = ovf | idx[COL_IDX_W-1];
                idx  = {idx[COL_IDX_W-2:0], shifted[0]};
            end
        end
        res.used = used;
        // index past the column gives a 0 state
        res.nbit = ovf ? 1'b0 : column[idx];
    end

endmodule

`default_nettype wire

// ===== design/boolean_network_sync_update.sv =====
// Top level of the boolean network synchronous update block: sequencer, state and registers.
// Instantiates bnsu_tables and bnsu_eval; depends on bnsu_pkg.
//
//  Channel   Signals                                       Direction
//  -------   --------------------------------------------  ---------
//  in        in_valid/in_stall + action..state_vector_in   into block
//  out       out_valid/out_stall + state_vector_out        out of block
//  cfg       cfg_write, cfg_index, cfg_data                into block
//
// Load actions complete in their transfer cycle. A step sweeps min(active_genes, MAX_GENES) genes
// in the run state, then waits in the finish state until the output register is free:
// one wiring row and one truth column are read per cycle from the single table read port.
// in_stall is high from step transfer until its result is parked in the output register.
// Loads are still taken while a result waits on out_stall.
// Reset is immediate: wiring rows are marked unused by valid flops, no clearing pass.
`default_nettype none

module boolean_network_sync_update #(
    parameter int MAX_GENES  = bnsu_pkg::MAX_GENES_DEF,
    parameter int MAX_INPUTS = bnsu_pkg::MAX_INPUTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [bnsu_pkg::ACTION_W-1:0]       action,
    input  wire logic [bnsu_pkg::GENE_W-1:0]         gene,
    input  wire logic [bnsu_pkg::SLOT_W-1:0]         slot,
    input  wire logic [bnsu_pkg::SRC_W-1:0]          source_gene,
    input  wire logic [bnsu_pkg::COL_W-1:0]          truth_column,
    input  wire logic [bnsu_pkg::VEC_W-1:0]          state_vector_in,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [bnsu_pkg::VEC_W-1:0]          state_vector_out,
    input  wire logic                                cfg_write,
    input  wire logic [bnsu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bnsu_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bnsu_pkg::*;

    localparam int GIdxW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
    localparam int CntW  = $clog2(MAX_GENES + 1);

    // Sequencer state
    fsm_t                  fsm_reg, fsm_next;
    logic [CntW-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [GIdxW-1:0]      ev_gene_reg, ev_gene_next;

    // Network state: gene_states_reg is the held vector, next_vec_reg collects the step
    logic [MAX_GENES-1:0]  gene_states_reg, gene_states_next;
    logic [MAX_GENES-1:0]  next_vec_reg, next_vec_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [VEC_W-1:0]      out_data_reg, out_data_next;

    // Configuration
    logic [AGENES_W-1:0]   active_genes_reg;
    logic [AINPUTS_W-1:0]  active_inputs_reg;

    logic                  in_xfer;
    logic                  rd_more;
    logic [CntW-1:0]       gene_limit;
    logic [GIdxW-1:0]      rd_addr;
    tbl_wr_t               tbl_wr;
    eval_res_t             ev_res;

    logic [MAX_INPUTS-1:0][SRC_W-1:0] tbl_src;
    logic [COL_W-1:0]                 tbl_col;

    assign in_stall         = (fsm_reg != ST_IDLE);
    assign in_xfer          = in_valid && !in_stall;
    assign out_valid        = out_valid_reg;
    assign state_vector_out = out_data_reg;

    // Register values above the maximum saturate.
    assign gene_limit = (int'(active_genes_reg) > MAX_GENES) ? CntW'(MAX_GENES)
                                                             : CntW'(active_genes_reg);
    assign rd_more    = (rd_cnt_reg < gene_limit);
    assign rd_addr    = rd_cnt_reg[GIdxW-1:0];

    // Loads go straight to the tables in the transfer cycle.
    always_comb
    begin
        tbl_wr.wire_we = in_xfer && (action_t'(action) == ACT_WIRE);
        tbl_wr.col_we  = in_xfer && (action_t'(action) == ACT_COLUMN);
        tbl_wr.gene    = gene;
        tbl_wr.slot    = slot;
        tbl_wr.src     = source_gene;
        tbl_wr.column  = truth_column;
    end

    bnsu_tables #(
        .MAX_GENES  (MAX_GENES),
        .MAX_INPUTS (MAX_INPUTS)
    ) u_tables (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .src     (tbl_src),
        .column  (tbl_col)
    );

    // Evaluates the gene whose row was read last cycle, against the old state.
    bnsu_eval #(
        .MAX_GENES  (MAX_GENES),
        .MAX_INPUTS (MAX_INPUTS)
    ) u_eval (
        .src           (tbl_src),
        .column        (tbl_col),
        .state_vec     (gene_states_reg),
        .active_inputs (active_inputs_reg),
        .res           (ev_res)
    );

    always_comb
    begin
        fsm_next         = fsm_reg;
        rd_cnt_next      = rd_cnt_reg;
        ev_valid_next    = 1'b0;
        ev_gene_next     = ev_gene_reg;
        gene_states_next = gene_states_reg;
        next_vec_next    = next_vec_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;

        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (action_t'(action))
                        ACT_WIRE, ACT_COLUMN:
                        begin
                            // handled by the table write port
                        end
                        ACT_STATE:
                        begin
                            gene_states_next = MAX_GENES'(state_vector_in);
                        end
                        ACT_STEP:
                        begin
                            next_vec_next = gene_states_reg;
                            rd_cnt_next   = '0;
                            fsm_next      = ST_RUN;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // read gene rd_cnt while evaluating the previous one
                if (rd_more)
                begin
                    ev_valid_next = 1'b1;
                    ev_gene_next  = rd_addr;
                    rd_cnt_next   = rd_cnt_reg + CntW'(1);
                end
                else if (!ev_valid_reg)
                begin
                    fsm_next = ST_FINISH;
                end
                if (ev_valid_reg && ev_res.used)
                begin
                    next_vec_next[ev_gene_reg] = ev_res.nbit;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    gene_states_next = next_vec_reg;
                    out_data_next    = VEC_W'(next_vec_reg);
                    out_valid_next   = 1'b1;
                    fsm_next         = ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg <= ST_IDLE;
        end
        else
        begin
            fsm_reg <= fsm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg      <= '0;
            ev_valid_reg    <= 1'b0;
            gene_states_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_cnt_reg      <= rd_cnt_next;
            ev_valid_reg    <= ev_valid_next;
            gene_states_reg <= gene_states_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_gene_reg  <= ev_gene_next;
        next_vec_reg <= next_vec_next;
        out_data_reg <= out_data_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_genes_reg  <= AGENES_RST;
            active_inputs_reg <= AINPUTS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ACTIVE_GENES:  active_genes_reg  <= cfg_data[AGENES_W-1:0];
                CFG_ACTIVE_INPUTS: active_inputs_reg <= cfg_data[AINPUTS_W-1:0];
            endcase
        end
    end

    // An evaluation slot only exists while a step is running.
    a_eval_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg |-> fsm_reg == ST_RUN)
        else $error("evaluation pending outside a step");

    // A result only appears at the end of a step.
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fsm_reg) == ST_FINISH)
        else $error("result appeared without a finished step");

    // A step transfer starts the gene sweep.
    a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && action_t'(action) == ACT_STEP) |=> fsm_reg == ST_RUN)
        else $error("step transfer did not start the sweep");

endmodule

`default_nettype wire
